### src/afsc_pkg.sv
// Shared constants, types and the skip pattern for the auto frame skip controller.
`timescale 1ns / 1ps

package afsc_pkg;

    localparam int LEVELS     = 12;
    localparam int LEVEL_W    = 4;
    localparam int SPEED_W    = 16;
    localparam int DEBT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_ON   = 3'd4;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 4'(LEVELS - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_DEBT_LO = 4'd8;

    // 1e6*S >= 995*T*R  <=>  200000*S >= 199*T*R
    localparam int FAST_SPEED_K = 200000;
    localparam int FAST_LIMIT_K = 199;
    // 1e6*S < 800*T*R   <=>  1250*S < T*R
    localparam int SLOW_SPEED_K = 1250;

    localparam int DEBT_SCALE = 500;
    localparam int DIVIDEND_W = 20;
    localparam int QUOT_W     = 11;

    // x/500 == (((x >> 2) * 268436) >> 25) for every x below 2^20
    localparam int DIV_PRE_SHIFT = 2;
    localparam int DIV_RECIP     = 268436;
    localparam int DIV_SHIFT     = 25;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    function automatic logic skip_bit(input logic [LEVEL_W-1:0] level,
                                      input logic [LEVEL_W-1:0] phase);
        logic [LEVELS-1:0] row;
        unique case (level)
            4'd0:    row = 12'h000;
            4'd1:    row = 12'h800;
            4'd2:    row = 12'h820;
            4'd3:    row = 12'h888;
            4'd4:    row = 12'h924;
            4'd5:    row = 12'hA52;
            4'd6:    row = 12'hAAA;
            4'd7:    row = 12'hB5A;
            4'd8:    row = 12'hDB6;
            4'd9:    row = 12'hEEE;
            4'd10:   row = 12'hFBE;
            4'd11:   row = 12'hFFE;
            default: row = 12'h000;
        endcase
        skip_bit = (phase < 4'(LEVELS)) ? row[phase] : 1'b0;
    endfunction

endpackage

### src/afsc_div.sv
// Divider of a magnitude by the debt scale through a registered reciprocal multiply.
`timescale 1ns / 1ps

module afsc_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  afsc_pkg::t_div_ctrl     i_ctrl,
    output afsc_pkg::t_div_status   o_status,
    output logic [afsc_pkg::QUOT_W-1:0] o_quot
);
    import afsc_pkg::*;

    localparam int PRE_W   = DIVIDEND_W - DIV_PRE_SHIFT;
    localparam int RECIP_W = 19;
    localparam int PROD_W  = DIV_SHIFT + QUOT_W;

    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(DIV_RECIP);

    logic [PRE_W-1:0]  r_pre;
    logic [QUOT_W-1:0] r_quot;
    logic              r_busy;
    logic              r_done;
    logic [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(r_pre) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_pre <= i_ctrl.dividend[DIVIDEND_W-1:DIV_PRE_SHIFT];
        end else if (r_busy) begin
            r_quot <= w_prod[PROD_W-1:DIV_SHIFT];
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;

endmodule

### src/auto_frame_skip_controller.sv
// Top level of the auto frame skip controller: sequencer, shared multiplier and state.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_ready) carries one frame's measured speed
//   and the paused, menu and fast-forward flags. Output channel (o_out_valid /
//   i_out_ready) returns the skip decision for the next frame, the level used
//   and whether auto mode was in effect. One result per input transfer.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
//   user must do so only while the block is idle, which it does not enforce.
//   A start_level write also loads the skip level. A frame without adaptation
//   goes from idle to the finish state. An adapting frame makes four passes
//   through the shared 32x18 multiplier, then decides: a fast frame goes to
//   finish, a slow one through settle, and one below 80% first waits on the
//   reciprocal divide by the debt scale, which rescales the debt. One frame
//   is in work at a time; the next is taken only once the block is idle.
//   A finished result waits in the output register; the block returns to idle
//   and takes the next frame, which then holds until the output is taken.
//   Reset (synchronous, active low) restores the register defaults, level 0,
//   phase 0 and zero debt.
module auto_frame_skip_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [afsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [afsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [afsc_pkg::SPEED_W-1:0]      i_measured_speed,
    input  logic                              i_paused,
    input  logic                              i_menu_active,
    input  logic                              i_fast_forward,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_skip_next,
    output logic [afsc_pkg::LEVEL_W-1:0]      o_effective_level,
    output logic                              o_auto_active
);
    import afsc_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_MUL_TR    = 4'd1;
    localparam logic [3:0] ST_MUL_LIM   = 4'd2;
    localparam logic [3:0] ST_MUL_FAST  = 4'd3;
    localparam logic [3:0] ST_MUL_SLOW  = 4'd4;
    localparam logic [3:0] ST_DECIDE    = 4'd5;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd6;
    localparam logic [3:0] ST_SETTLE    = 4'd7;
    localparam logic [3:0] ST_FINISH    = 4'd8;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int D_W     = QUOT_W + 1;
    localparam int A_W     = DIVIDEND_W + 2;

    logic [3:0]               r_state;
    logic [SPEED_W-1:0]       r_target;
    logic [SPEED_W-1:0]       r_rate;
    logic                     r_auto_en;
    logic                     r_throttle_on;
    logic [LEVEL_W-1:0]       r_level;
    logic [LEVEL_W-1:0]       r_phase;
    logic signed [DEBT_W-1:0] r_debt;

    logic [SPEED_W-1:0]       r_speed;
    logic                     r_ff;
    logic                     r_auto;

    logic [31:0]              r_tr;
    logic [39:0]              r_lim;
    logic [33:0]              r_sfast;
    logic [26:0]              r_sslow;
    logic signed [D_W-1:0]    r_d;

    logic                     r_out_valid;
    logic                     r_out_skip;
    logic [LEVEL_W-1:0]       r_out_level;
    logic                     r_out_auto;

    logic [MUL_A_W-1:0]       w_mul_a;
    logic [MUL_B_W-1:0]       w_mul_b;
    logic [PROD_W-1:0]        w_prod;
    logic                     w_in_xfer;
    logic                     w_throttling;
    logic                     w_auto;
    logic                     w_fast;
    logic                     w_below;
    logic signed [DEBT_W-1:0] w_debt_inc;
    logic signed [A_W-1:0]    w_a;
    logic [A_W-1:0]           w_a_mag;
    logic signed [D_W-1:0]    w_debt_ext;
    logic [D_W-1:0]           w_k;
    logic [D_W-1:0]           w_lv;
    logic [LEVEL_W-1:0]       w_next_phase;
    logic [LEVEL_W-1:0]       w_eff;
    logic                     w_out_free;
    t_div_ctrl                w_div_ctrl;
    t_div_status              w_div_status;
    logic [QUOT_W-1:0]        w_quot;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign w_in_xfer    = i_in_valid && o_in_ready;
    assign w_throttling = (i_paused || i_menu_active) ? 1'b1
                        : (i_fast_forward ? 1'b0 : r_throttle_on);
    assign w_auto       = !(i_fast_forward || i_paused) && r_auto_en;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_MUL_TR: begin
                w_mul_a = MUL_A_W'(r_target);
                w_mul_b = MUL_B_W'(r_rate);
            end
            ST_MUL_LIM: begin
                w_mul_a = r_tr;
                w_mul_b = MUL_B_W'(FAST_LIMIT_K);
            end
            ST_MUL_FAST: begin
                w_mul_a = MUL_A_W'(r_speed);
                w_mul_b = MUL_B_W'(FAST_SPEED_K);
            end
            ST_MUL_SLOW: begin
                w_mul_a = MUL_A_W'(r_speed);
                w_mul_b = MUL_B_W'(SLOW_SPEED_K);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod     = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_fast     = (40'(r_sfast) >= r_lim);
    assign w_below    = (32'(r_sslow) < r_tr);
    assign w_debt_inc = r_debt + 3'sd1;

    assign w_a = A_W'(r_debt) * A_W'(signed'(DEBT_SCALE))
               + signed'(A_W'(r_speed)) * A_W'(signed'(10))
               - signed'(A_W'(r_target)) * A_W'(signed'(9));
    assign w_a_mag = w_a[A_W-1] ? A_W'(-w_a) : A_W'(w_a);

    assign w_div_ctrl.start    = (r_state == ST_DECIDE) && !w_fast && w_below;
    assign w_div_ctrl.dividend = w_a_mag[DIVIDEND_W-1:0];

    afsc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_div_ctrl),
        .o_status (w_div_status),
        .o_quot   (w_quot)
    );

    assign w_debt_ext   = D_W'(r_debt);
    assign w_k          = D_W'(-r_d) >> 1;
    assign w_lv         = D_W'(r_level) + w_k;
    assign w_next_phase = (r_phase >= LEVEL_MAX) ? '0 : r_phase + 1'b1;
    assign w_eff        = r_ff ? LEVEL_MAX : r_level;
    assign w_out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_target      <= 16'd1000;
            r_rate        <= 16'd1000;
            r_auto_en     <= 1'b0;
            r_throttle_on <= 1'b1;
            r_level       <= '0;
            r_phase       <= '0;
            r_debt        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_TARGET_SPEED:  r_target      <= i_cfg_data;
                    REG_THROTTLE_RATE: r_rate        <= i_cfg_data;
                    REG_AUTO_ENABLE:   r_auto_en     <= i_cfg_data[0];
                    REG_START_LEVEL: begin
                        r_level <= (i_cfg_data[LEVEL_W-1:0] > LEVEL_MAX) ? LEVEL_MAX
                                 : i_cfg_data[LEVEL_W-1:0];
                    end
                    REG_THROTTLE_ON:   r_throttle_on <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= (w_throttling && w_auto && r_phase == '0)
                                 ? ST_MUL_TR : ST_FINISH;
                    end
                end
                ST_MUL_TR:   r_state <= ST_MUL_LIM;
                ST_MUL_LIM:  r_state <= ST_MUL_FAST;
                ST_MUL_FAST: r_state <= ST_MUL_SLOW;
                ST_MUL_SLOW: r_state <= ST_DECIDE;
                ST_DECIDE: begin
                    if (w_fast) begin
                        if (r_debt >= 3'sd2) begin
                            r_debt <= '0;
                            if (r_level != '0) begin
                                r_level <= r_level - 1'b1;
                            end
                        end else begin
                            r_debt <= w_debt_inc;
                        end
                        r_state <= ST_FINISH;
                    end else if (w_below) begin
                        r_state <= ST_DIV_WAIT;
                    end else begin
                        r_state <= ST_SETTLE;
                    end
                end
                ST_DIV_WAIT: begin
                    if (w_div_status.done) begin
                        r_state <= ST_SETTLE;
                    end
                end
                ST_SETTLE: begin
                    if (r_d >= 12'sd3) begin
                        r_debt <= 3'sd3;
                    end else if (r_d <= -12'sd2) begin
                        r_level <= (w_lv > D_W'(LEVEL_MAX)) ? LEVEL_MAX
                                 : w_lv[LEVEL_W-1:0];
                        r_debt  <= r_d[0] ? -3'sd1 : 3'sd0;
                    end else begin
                        r_debt <= r_d[DEBT_W-1:0];
                    end
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_phase     <= w_next_phase;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FINISH && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_speed <= i_measured_speed;
            r_ff    <= i_fast_forward;
            r_auto  <= w_auto;
        end
        case (r_state)
            ST_MUL_TR:   r_tr    <= w_prod[31:0];
            ST_MUL_LIM:  r_lim   <= w_prod[39:0];
            ST_MUL_FAST: r_sfast <= w_prod[33:0];
            ST_MUL_SLOW: r_sslow <= w_prod[26:0];
            ST_DECIDE:   r_d     <= w_debt_ext - D_W'(r_level < LEVEL_DEBT_LO);
            ST_DIV_WAIT: begin
                if (w_div_status.done) begin
                    r_d <= w_a[A_W-1] ? -signed'(D_W'(w_quot)) : signed'(D_W'(w_quot));
                end
            end
            default: ;
        endcase
        if (r_state == ST_FINISH && w_out_free) begin
            r_out_skip  <= skip_bit(w_eff, w_next_phase);
            r_out_level <= w_eff;
            r_out_auto  <= r_auto;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_skip_next       = r_out_skip;
    assign o_effective_level = r_out_level;
    assign o_auto_active     = r_out_auto;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LEVEL_MAX)
        else $error("skip level above top row");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= LEVEL_MAX)
        else $error("phase counter out of range");

    a_debt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_debt >= -3'sd1)
        else $error("adjust debt below settled range");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_status.done |-> r_state == ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_div_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV_WAIT && !w_div_status.done |-> w_div_status.busy)
        else $error("waiting on an idle divider");

endmodule

### tb/tb_auto_frame_skip_controller.sv
// Self-checking testbench for the auto frame skip controller: directed and random frames.
`timescale 1ns / 1ps

module tb_auto_frame_skip_controller;

    import afsc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_FRAMES = 500;
    localparam int SETTING_SPAN  = 42;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = 3'd7;

    typedef enum int {
        SPEED_FAST, SPEED_NEAR_FAST, SPEED_MID, SPEED_NEAR_SLOW,
        SPEED_LOW, SPEED_EXTREME, SPEED_ANY
    } speed_band_e;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               paused;
        logic               menu;
        logic               ff;
    } frame_t;

    typedef struct packed {
        logic               skip;
        logic [LEVEL_W-1:0] level;
        logic               auto_on;
    } decision_t;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [SPEED_W-1:0]    frame_speed = '0;
    logic                  frame_paused = 1'b0;
    logic                  frame_menu   = 1'b0;
    logic                  frame_ff     = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic                  skip_next;
    logic [LEVEL_W-1:0]    eff_level;
    logic                  auto_active;

    logic [SPEED_W-1:0] cfg_target   = 16'd1000;
    logic [SPEED_W-1:0] cfg_rate     = 16'd1000;
    logic               cfg_auto     = 1'b0;
    logic [LEVEL_W-1:0] cfg_start    = '0;
    logic               cfg_throttle = 1'b1;
    logic [LEVEL_W-1:0] level_state  = '0;
    logic [LEVEL_W-1:0] phase_state  = '0;
    longint             debt_state   = 0;

    decision_t   pending_decisions [$];
    int          error_count    = 0;
    int          frames_sent    = 0;
    int          results_seen   = 0;
    int          reg_writes     = 0;
    int          settings_used  = 0;
    int          adapt_frames   = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          cycle_count    = 0;
    speed_band_e speed_band     = SPEED_FAST;

    auto_frame_skip_controller i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_measured_speed  (frame_speed),
        .i_paused          (frame_paused),
        .i_menu_active     (frame_menu),
        .i_fast_forward    (frame_ff),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_skip_next       (skip_next),
        .o_effective_level (eff_level),
        .o_auto_active     (auto_active)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [0:LEVELS-1] pattern_row(input logic [LEVEL_W-1:0] level);
        case (level)
            4'd0:    pattern_row = 12'b000000000000;
            4'd1:    pattern_row = 12'b000000000001;
            4'd2:    pattern_row = 12'b000001000001;
            4'd3:    pattern_row = 12'b000100010001;
            4'd4:    pattern_row = 12'b001001001001;
            4'd5:    pattern_row = 12'b010010100101;
            4'd6:    pattern_row = 12'b010101010101;
            4'd7:    pattern_row = 12'b010110101101;
            4'd8:    pattern_row = 12'b011011011011;
            4'd9:    pattern_row = 12'b011101110111;
            4'd10:   pattern_row = 12'b011111011111;
            default: pattern_row = 12'b011111111111;
        endcase
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TARGET_SPEED:  cfg_target = data;
            REG_THROTTLE_RATE: cfg_rate = data;
            REG_AUTO_ENABLE:   cfg_auto = data[0];
            REG_START_LEVEL: begin
                cfg_start   = data[LEVEL_W-1:0];
                level_state = (cfg_start > LEVEL_MAX) ? LEVEL_MAX : cfg_start;
            end
            REG_THROTTLE_ON:   cfg_throttle = data[0];
            default: ;
        endcase
    endfunction

    function automatic decision_t predict_skip(input frame_t f);
        logic               throttling;
        logic               auto_on;
        longint             t_val;
        longint             r_val;
        longint             s_val;
        longint             tr;
        longint             lhs;
        longint             d;
        longint             k;
        longint             lv;
        logic [LEVEL_W-1:0] eff;
        logic [0:LEVELS-1]  row;
        decision_t          r;
        throttling = (f.paused || f.menu) ? 1'b1 : (f.ff ? 1'b0 : cfg_throttle);
        auto_on    = (f.ff || f.paused) ? 1'b0 : cfg_auto;
        if (throttling && auto_on && phase_state == 0) begin
            adapt_frames++;
            t_val = cfg_target;
            r_val = cfg_rate;
            s_val = f.speed;
            tr    = t_val * r_val;
            lhs   = 1000000 * s_val;
            if (lhs >= 995 * tr) begin
                debt_state++;
                if (debt_state >= 3) begin
                    debt_state = 0;
                    if (level_state > 0) level_state--;
                end
            end else begin
                d = debt_state;
                if (lhs < 800 * tr) begin
                    d = (500 * d - 9 * t_val + 10 * s_val) / 500;
                end else if (level_state < LEVEL_DEBT_LO) begin
                    d = d - 1;
                end
                if (d >= 3) begin
                    debt_state = 3;
                end else begin
                    if (d <= -2) begin
                        k  = (-d) / 2;
                        lv = longint'(level_state) + k;
                        d  = d + 2 * k;
                        level_state = (lv > LEVELS - 1) ? LEVEL_MAX : LEVEL_W'(lv);
                    end
                    debt_state = d;
                end
            end
        end
        phase_state = (phase_state == LEVELS - 1) ? '0 : phase_state + 1'b1;
        eff = f.ff ? LEVEL_MAX : level_state;
        row = pattern_row(eff);
        r.skip    = row[phase_state];
        r.level   = eff;
        r.auto_on = auto_on;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk) begin
        decision_t want;
        if (out_valid === 1'b1 && out_ready) begin
            results_seen++;
            if (pending_decisions.size() == 0) begin
                flag_mismatch("result transfer with no frame outstanding");
            end else begin
                want = pending_decisions.pop_front();
                if (skip_next !== want.skip)
                    flag_mismatch($sformatf("skip_next %b, want %b", skip_next, want.skip));
                if (eff_level !== want.level)
                    flag_mismatch($sformatf("effective_level %0d, want %0d",
                                            eff_level, want.level));
                if (auto_active !== want.auto_on)
                    flag_mismatch($sformatf("auto_active %b, want %b",
                                            auto_active, want.auto_on));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_auto_frame_skip_controller: errors");
            $finish;
        end else begin
            cycle_count <= cycle_count + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg_write(idx, data);
        reg_writes++;
    endtask

    task automatic close_writes();
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic send_frame(input logic [SPEED_W-1:0] speed, input logic paused,
                              input logic menu, input logic ff);
        frame_t f;
        f = '{speed: speed, paused: paused, menu: menu, ff: ff};
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid     <= 1'b1;
        frame_speed  <= speed;
        frame_paused <= paused;
        frame_menu   <= menu;
        frame_ff     <= ff;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_decisions.push_back(predict_skip(f));
        frames_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic longint clamp_speed(input longint v);
        return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
    endfunction

    function automatic frame_t random_frame();
        longint tr;
        longint fast_thr;
        longint slow_thr;
        longint lo;
        longint hi;
        longint s;
        frame_t f;
        if (phase_state == 0 && $urandom_range(99) < 35)
            speed_band = speed_band_e'($urandom_range(SPEED_ANY));
        tr       = longint'(cfg_target) * longint'(cfg_rate);
        fast_thr = (995 * tr + 999999) / 1000000;
        slow_thr = (800 * tr + 999999) / 1000000;
        case (speed_band)
            SPEED_FAST:      s = fast_thr + $urandom_range(50);
            SPEED_NEAR_FAST: s = fast_thr - 2 + $urandom_range(4);
            SPEED_MID: begin
                lo = clamp_speed(slow_thr);
                hi = clamp_speed(fast_thr - 1);
                s  = (hi >= lo) ? lo + $urandom_range(int'(hi - lo)) : lo;
            end
            SPEED_NEAR_SLOW: s = slow_thr - 2 + $urandom_range(4);
            SPEED_LOW:       s = $urandom_range(int'(clamp_speed(slow_thr)));
            SPEED_EXTREME:   s = $urandom_range(1) ? 65535 : 0;
            default:         s = $urandom_range(65535);
        endcase
        f.speed  = SPEED_W'(clamp_speed(s));
        f.paused = ($urandom_range(99) < 8);
        f.menu   = ($urandom_range(99) < 10);
        f.ff     = ($urandom_range(99) < 10);
        return f;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_rate_value();
        case ($urandom_range(7))
            0:       return 16'd1000;
            1:       return 16'd0;
            2:       return 16'd1;
            3:       return 16'hFFFF;
            4, 5:    return CFG_DATA_W'($urandom_range(2000, 500));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic pick_setting();
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        write_reg(REG_TARGET_SPEED, pick_rate_value());
        write_reg(REG_THROTTLE_RATE, pick_rate_value());
        write_reg(REG_AUTO_ENABLE, {junk[15:1], ($urandom_range(99) < 85)});
        write_reg(REG_THROTTLE_ON, {junk[14:0], ($urandom_range(99) < 85)});
        if ($urandom_range(1))
            write_reg(REG_START_LEVEL, {junk[11:0], 4'($urandom_range(15))});
        if ($urandom_range(7) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LAST, REG_UNMAPPED_FIRST)), junk);
        close_writes();
    endtask

    task automatic test_debt_extremes();
        logic [SPEED_W-1:0] filler [4] = '{16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};
        write_reg(REG_TARGET_SPEED, 16'hFFFF);
        write_reg(REG_AUTO_ENABLE, 16'hFFFF);
        close_writes();
        // phase is zero after reset: a stalled frame at the top target builds a huge debt
        send_frame(16'd0, 1'b0, 1'b0, 1'b0);
        for (int i = 1; i < LEVELS; i++) send_frame(filler[i % 4], i[0], i[1], i[2]);
        drain_results();
        write_reg(REG_TARGET_SPEED, 16'd1000);
        write_reg(REG_THROTTLE_RATE, 16'hFFFF);
        close_writes();
        send_frame(16'd40000, 1'b0, 1'b0, 1'b0);
        for (int i = 1; i < LEVELS; i++) send_frame(filler[(i + 1) % 4], i[2], i[0], i[1]);
        drain_results();
        write_reg(REG_TARGET_SPEED, 16'd0);
        close_writes();
        send_frame(16'd0, 1'b0, 1'b0, 1'b0);
        drain_results();
    endtask

    task automatic test_register_writes();
        write_reg(REG_START_LEVEL, 16'hFFFF);
        close_writes();
        send_frame(16'd1000, 1'b0, 1'b0, 1'b0);
        send_frame(16'd1000, 1'b1, 1'b1, 1'b1);
        drain_results();
        write_reg(REG_START_LEVEL, 16'd12);
        close_writes();
        send_frame(16'd999, 1'b0, 1'b1, 1'b0);
        drain_results();
        write_reg(REG_START_LEVEL, 16'hFFF3);
        for (int i = REG_UNMAPPED_FIRST; i <= REG_UNMAPPED_LAST; i++)
            write_reg(CFG_IDX_W'(i), 16'hFFFF);
        write_reg(REG_THROTTLE_RATE, 16'd0);
        write_reg(REG_THROTTLE_ON, 16'hFFFE);
        close_writes();
        send_frame(16'd500, 1'b0, 1'b1, 1'b0);
        send_frame(16'd500, 1'b0, 1'b0, 1'b0);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int send_pct [4] = '{0, 60, 0, 17};
        int recv_pct [4] = '{0, 0, 60, 17};
        frame_t f;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            for (int n = 0; n < RANDOM_FRAMES / 4; n++) begin
                if (n % SETTING_SPAN == 0) begin
                    drain_results();
                    pick_setting();
                end else if ($urandom_range(49) == 0) begin
                    drain_results();
                end
                f = random_frame();
                send_frame(f.speed, f.paused, f.menu, f.ff);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_debt_extremes();
        test_register_writes();
        test_random_traffic();
        drain_results();
        if (pending_decisions.size() != 0)
            flag_mismatch($sformatf("%0d decisions never arrived", pending_decisions.size()));
        $display("ran %0d frames (%0d adapting) and got %0d decisions back",
                 frames_sent, adapt_frames, results_seen);
        $display("used %0d register settings over %0d writes, %0d mismatches",
                 settings_used, reg_writes, error_count);
        if (error_count == 0) begin
            $display("tb_auto_frame_skip_controller: clean");
        end else begin
            $display("tb_auto_frame_skip_controller: errors");
        end
        $finish;
    end

endmodule
